// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the AES-128 CBC codec RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hw/rtl/aescbc_pkg.sv =====
// Package for the AES-128 CBC codec: word types, commands, AES tables and helpers.
// No dependencies.
package aescbc_pkg;

   typedef struct packed {
      logic        mode;
      logic        is_iv;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  byte_count;
      logic        last_block;
   } req_word_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  out_bytes;
      logic        out_last;
      logic        pad_error;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_ENC      = 2'd0,
      CMD_ENC_FULL = 2'd1,
      CMD_DEC      = 2'd2,
      CMD_IV       = 2'd3
   } cmd_type;

   // queued operation between front and back
   typedef struct packed {
      cmd_type      cmd;
      logic [127:0] data;
      logic         last;
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_EMIT  = 2'd2
   } eng_state_type;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;
   localparam int unsigned ROUNDS = 10;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (SBOX[i] == v) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte k of a block, byte 0 in the top bits
   function automatic logic [7:0] gb(input logic [127:0] s, input int k);
      return s[127 - 8*k -: 8];
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4*c] = SBOX[gb(s, r + 4*((c + r) % 4))];
         end
      end
      if (!final_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8*i -: 8] = t[i];
      end
      return o ^ rk;
   endfunction

   function automatic logic [7:0] m9(input logic [7:0] a);
      return xt(xt(xt(a))) ^ a;
   endfunction
   function automatic logic [7:0] m11(input logic [7:0] a);
      return xt(xt(xt(a))) ^ xt(a) ^ a;
   endfunction
   function automatic logic [7:0] m13(input logic [7:0] a);
      return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
   endfunction
   function automatic logic [7:0] m14(input logic [7:0] a);
      return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4*c] = inv_sbox(gb(s, r + 4*((c - r + 4) % 4)));
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8*i -: 8] = t[i];
      end
      o = o ^ rk;
      if (!final_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = gb(o, 4*c); a1 = gb(o, 4*c+1); a2 = gb(o, 4*c+2); a3 = gb(o, 4*c+3);
            t[4*c]   = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
            t[4*c+1] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
            t[4*c+2] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
            t[4*c+3] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
         end
         for (int i = 0; i < 16; i++) begin
            o[127 - 8*i -: 8] = t[i];
         end
      end
      return o;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // previous round key from the next one
   function automatic logic [127:0] key_prev(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rc_inv(input logic [7:0] a);
      return a[0] ? ({1'b0, a[7:1]} ^ 8'h8d) : {1'b0, a[7:1]};
   endfunction

endpackage

// ===== hw/rtl/aescbc_front.sv =====
// Front end: accepts words, tags IV loads, pads the last encrypt block.
// Depends on aescbc_pkg.
module aescbc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  aescbc_pkg::req_word_type  req_word,
   output logic                      op_push,
   output aescbc_pkg::op_type        op_word,
   input  logic                      op_full
);
   logic [4:0]   cnt;
   logic [127:0] padded;
   logic [7:0]   padv;

   assign req_ready = !op_full;
   // IV words go through the queue too, so they stay in order with the blocks
   assign op_push   = req_valid && req_ready;

   always_comb begin
      cnt    = (req_word.byte_count > 5'd16) ? 5'd16 : req_word.byte_count;
      padv   = 8'(5'd16 - cnt);
      padded = {req_word.data_high, req_word.data_low};
      for (int i = 0; i < 16; i++) begin
         if (5'(i) >= cnt) begin
            padded[127 - 8*i -: 8] = padv;
         end
      end
      op_word.last = req_word.last_block;
      if (req_word.is_iv) begin
         op_word.cmd  = aescbc_pkg::CMD_IV;
         op_word.data = {req_word.data_high, req_word.data_low};
      end else if (req_word.mode) begin
         op_word.cmd  = aescbc_pkg::CMD_DEC;
         op_word.data = {req_word.data_high, req_word.data_low};
      end else if (req_word.last_block && cnt == 5'd16) begin
         op_word.cmd  = aescbc_pkg::CMD_ENC_FULL;
         op_word.data = {req_word.data_high, req_word.data_low};
      end else begin
         op_word.cmd  = aescbc_pkg::CMD_ENC;
         op_word.data = req_word.last_block ? padded : {req_word.data_high, req_word.data_low};
      end
   end
endmodule

// ===== hw/rtl/aescbc_fifo.sv =====
// Two-entry queue between front end and cipher engine.
// Depends on aescbc_pkg.
module aescbc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aescbc_pkg::op_type push_word,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output aescbc_pkg::op_type pop_word
);
   aescbc_pkg::op_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_word = mem_ff[rp_ff];
   assign cnt_in   = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_ff ^ push;
         rp_ff  <= rp_ff ^ pop;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hw/rtl/aescbc_engine.sv =====
// Back end: iterative AES-128 round unit with on-the-fly key schedule, CBC chain,
// padding block generation and pad stripping. Depends on aescbc_pkg.
module aescbc_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [127:0]              key,
   input  logic                      op_empty,
   input  aescbc_pkg::op_type        op_word,
   output logic                      op_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output aescbc_pkg::rsp_word_type  rsp_word,
   output logic                      busy
);
   aescbc_pkg::eng_state_type state_ff, state_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] dkey_ff, dkey_in;      // last round key, for decrypt
   logic [127:0] chain_ff, chain_in;
   logic [127:0] prevc_ff, prevc_in;    // chain saved for decrypt XOR
   logic [7:0]   rc_ff, rc_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         dec_ff, dec_in, last_ff, last_in, extra_ff, extra_in;
   logic         dk_ok_ff, dk_ok_in;
   logic [127:0] kbase_ff;              // key the decrypt key was built from
   logic         ov_ff, ov_in;          // output register valid
   aescbc_pkg::rsp_word_type ow_ff, ow_in;
   logic         padbad_ff;             // last decrypt pad byte outside 1..16
   logic [4:0]   padn_ff;               // pad length of the last decrypt block
   logic [127:0] rnd_out, plain, stripped, strip_st;
   logic [7:0]   pad;
   logic         fin, out_free, iv_take, go, strip_ok;

   assign rsp_valid = ov_ff;
   assign rsp_word  = ow_ff;
   assign out_free  = !ov_ff || rsp_ready;
   assign busy      = state_ff != aescbc_pkg::ST_IDLE;

   // IV words are taken in idle without starting the round unit
   assign iv_take = !op_empty && op_word.cmd == aescbc_pkg::CMD_IV;
   assign go      = !op_empty && op_word.cmd != aescbc_pkg::CMD_IV &&
                    (op_word.cmd != aescbc_pkg::CMD_DEC || dk_ok_ff);

   always_comb begin
      rnd_out = dec_ff ? aescbc_pkg::dec_round(st_ff, rk_ff, rnd_ff == 4'd1)
                       : aescbc_pkg::enc_round(st_ff, rk_ff, rnd_ff == 4'(aescbc_pkg::ROUNDS));
      plain   = rnd_out ^ prevc_ff;
      pad     = plain[7:0];
      stripped = plain;
      // byte i from the bottom is a pad byte when i < pad
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < 5'(pad)) begin
            stripped[8*i +: 8] = 8'h00;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aescbc_pkg::ST_IDLE: begin
            if (go) begin
               state_in = aescbc_pkg::ST_RUN;
            end
         end
         aescbc_pkg::ST_RUN: begin
            if (fin) state_in = aescbc_pkg::ST_EMIT;
         end
         aescbc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = extra_ff ? aescbc_pkg::ST_RUN : aescbc_pkg::ST_IDLE;
            end
         end
         default: state_in = aescbc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_pop   = 1'b0;
      fin      = 1'b0;
      st_in    = st_ff;
      rk_in    = rk_ff;
      rc_in    = rc_ff;
      rnd_in   = rnd_ff;
      dec_in   = dec_ff;
      last_in  = last_ff;
      extra_in = extra_ff;
      chain_in = chain_ff;
      prevc_in = prevc_ff;
      dkey_in  = dkey_ff;
      dk_ok_in = dk_ok_ff && (key == kbase_ff);
      ov_in    = ov_ff && !rsp_ready;
      ow_in    = ow_ff;
      unique case (state_ff)
         aescbc_pkg::ST_IDLE: begin
            if (!dk_ok_ff) begin
               // build last round key forward, one round per cycle
               if (rnd_ff == 4'd0 || key != kbase_ff) begin
                  dkey_in = key;
                  rc_in   = 8'h01;
                  rnd_in  = 4'd1;
               end else begin
                  dkey_in = aescbc_pkg::key_next(dkey_ff, rc_ff);
                  rc_in   = aescbc_pkg::xt(rc_ff);
                  rnd_in  = rnd_ff + 4'd1;
                  if (rnd_ff == 4'(aescbc_pkg::ROUNDS)) begin
                     dk_ok_in = 1'b1;
                     rnd_in   = 4'd0;
                  end
               end
            end
            if (iv_take) begin
               op_pop   = 1'b1;
               chain_in = op_word.data;
            end
            if (go) begin
               op_pop   = 1'b1;
               dec_in   = op_word.cmd == aescbc_pkg::CMD_DEC;
               last_in  = op_word.last && op_word.cmd != aescbc_pkg::CMD_ENC_FULL;
               extra_in = op_word.cmd == aescbc_pkg::CMD_ENC_FULL;
               if (op_word.cmd == aescbc_pkg::CMD_DEC) begin
                  st_in    = op_word.data ^ dkey_ff;
                  rk_in    = aescbc_pkg::key_prev(dkey_ff, 8'h36);
                  rc_in    = 8'h36;
                  rnd_in   = 4'(aescbc_pkg::ROUNDS);
                  prevc_in = chain_ff;
                  chain_in = op_word.data;
               end else begin
                  st_in    = op_word.data ^ chain_ff ^ key;
                  rk_in    = aescbc_pkg::key_next(key, 8'h01);
                  rc_in    = 8'h02;
                  rnd_in   = 4'd1;
                  prevc_in = '0;
               end
            end
         end
         aescbc_pkg::ST_RUN: begin
            st_in = rnd_out;
            if (dec_ff) begin
               rc_in  = aescbc_pkg::rc_inv(rc_ff);
               rk_in  = aescbc_pkg::key_prev(rk_ff, aescbc_pkg::rc_inv(rc_ff));
               rnd_in = rnd_ff - 4'd1;
               fin    = rnd_ff == 4'd1;
            end else begin
               rk_in  = aescbc_pkg::key_next(rk_ff, rc_ff);
               rc_in  = aescbc_pkg::xt(rc_ff);
               rnd_in = rnd_ff + 4'd1;
               fin    = rnd_ff == 4'(aescbc_pkg::ROUNDS);
            end
            if (fin) begin
               st_in = plain;
               if (!dec_ff) chain_in = rnd_out;
            end
         end
         aescbc_pkg::ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               ow_in.out_high  = st_ff[127:64];
               ow_in.out_low   = st_ff[63:0];
               ow_in.out_bytes = 5'd16;
               ow_in.out_last  = last_ff;
               ow_in.pad_error = 1'b0;
               if (dec_ff && last_ff) begin
                  if (padbad_ff) begin
                     ow_in.pad_error = 1'b1;
                  end else begin
                     ow_in.out_bytes = 5'd16 - padn_ff;
                  end
               end
               if (extra_ff) begin
                  extra_in = 1'b0;
                  last_in  = 1'b1;
                  st_in    = {16{8'h10}} ^ chain_ff ^ key;
                  rk_in    = aescbc_pkg::key_next(key, 8'h01);
                  rc_in    = 8'h02;
                  rnd_in   = 4'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // strip applied on the cycle the result finishes
   always_comb begin
      strip_ok = dec_ff && last_ff && pad != 8'd0 && pad <= 8'd16;
      strip_st = strip_ok ? stripped : plain;
   end

   always_ff @(posedge clock) begin
      st_ff    <= (state_ff == aescbc_pkg::ST_RUN && fin) ? strip_st : st_in;
      rk_ff    <= rk_in;
      dkey_ff  <= dkey_in;
      prevc_ff <= prevc_in;
      ow_ff    <= ow_in;
      dec_ff   <= dec_in;
      last_ff  <= last_in;
      extra_ff <= extra_in;
      kbase_ff <= (state_ff == aescbc_pkg::ST_IDLE && !dk_ok_ff &&
                   (rnd_ff == 4'd0 || key != kbase_ff)) ? key : kbase_ff;
   end

   // pad byte is zeroed by stripping, so its check and length are kept aside
   always_ff @(posedge clock) begin
      if (state_ff == aescbc_pkg::ST_RUN && fin) begin
         padbad_ff <= !strip_ok;
         padn_ff   <= pad[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aescbc_pkg::ST_IDLE;
         chain_ff <= '0;
         rnd_ff   <= 4'd0;
         rc_ff    <= 8'h01;
         dk_ok_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         rnd_ff   <= rnd_in;
         rc_ff    <= rc_in;
         dk_ok_ff <= dk_ok_in;
         ov_ff    <= ov_in;
      end
   end
endmodule

// ===== hw/rtl/aes128_cbc_pkcs7_codec.sv =====
// AES-128 CBC codec with PKCS#7 padding. Top level.
// Depends on aescbc_pkg, aescbc_front, aescbc_fifo, aescbc_engine, assert_macros.svh.
//
// The key is written in two 64-bit halves through csr_*. Words enter on req_*;
// an IV word loads the chaining register and gives no result. Encrypt words are
// chained, padded on the last word (a full last word adds a whole padding block)
// and emitted on rsp_*. Decrypt words are chained and the last one has its
// padding stripped, with pad_error set instead of stripping when the pad byte is
// outside 1..16. A front stage classifies words into a two-entry queue; IV words
// travel the queue too and are taken by the idle engine, so they stay in order
// with the blocks. The back engine runs one AES round per cycle on a shared round
// unit, so a block passes through start, 10 rounds and emit, and a full last
// encrypt word adds a padding block that starts straight from emit. After a key
// change the first decrypt waits while the final round key is rebuilt. Results
// sit in an output register so the engine works on while the consumer stalls.
`include "assert_macros.svh"
module aes128_cbc_pkcs7_codec (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  aescbc_pkg::req_word_type  req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output aescbc_pkg::rsp_word_type  rsp_word,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [63:0]               csr_wdata
);
   logic [63:0] key_high_ff, key_low_ff;
   logic        op_push, op_full, op_pop, op_empty, busy;
   aescbc_pkg::op_type op_in_word, op_out_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            aescbc_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            aescbc_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   aescbc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .op_push, .op_word(op_in_word), .op_full
   );

   aescbc_fifo u_fifo (
      .clock, .reset, .push(op_push), .push_word(op_in_word), .full(op_full),
      .pop(op_pop), .empty(op_empty), .pop_word(op_out_word)
   );

   aescbc_engine u_engine (
      .clock, .reset, .key({key_high_ff, key_low_ff}),
      .op_empty, .op_word(op_out_word), .op_pop, .rsp_valid, .rsp_ready,
      .rsp_word, .busy
   );

   `ASSERT_IMPL(a_no_pop_empty, clock, reset, op_pop, !op_empty, "pop from empty queue")
   `ASSERT_IMPL(a_no_push_full, clock, reset, op_push, !op_full, "push into full queue")
   `ASSERT_NEXT(a_pop_busy, clock, reset, op_pop && op_out_word.cmd != aescbc_pkg::CMD_IV, busy, "engine idle after taking a word")
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the AES-128 CBC PKCS#7 codec (aes128_cbc_pkcs7_codec).
// Depends on aescbc_pkg for the word types and register indexes; holds its own AES model.
module testbench;

   // Scoreboard: tracks key and chaining block, predicts result words per accepted
   // request word, and checks them in order.
   class codec_scoreboard;
      bit [7:0]      fwd [256];
      bit [7:0]      rev [256];
      bit [127:0]    key;
      bit [127:0]    chain;
      bit [127:0]    rk [11];
      aescbc_pkg::rsp_word_type  pending [$];
      int            fails;

      function new();
         bit [7:0] v, p;
         for (int a = 0; a < 256; a++) begin
            // multiplicative inverse as a^254, then the affine map
            p = 8'h01;
            for (int e = 0; e < 254; e++) begin
               p = gmul(p, 8'(a));
            end
            if (a == 0) begin
               p = 8'h00;
            end
            v = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]}
                ^ {p[3:0], p[7:4]} ^ 8'h63;
            fwd[a] = v;
            rev[v] = 8'(a);
         end
         key = '0;
         chain = '0;
         fails = 0;
      endfunction

      function bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
         bit [7:0] r;
         r = 0;
         for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
               r ^= a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         end
         return r;
      endfunction

      function bit [7:0] at(bit [127:0] v, int k);
         return v[127 - 8*k -: 8];
      endfunction

      function void expand();
         bit [31:0] w [44];
         bit [31:0] t;
         bit [7:0]  rc;
         rc = 8'h01;
         for (int i = 0; i < 4; i++) begin
            w[i] = key[127 - 32*i -: 32];
         end
         for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
               t = {fwd[t[23:16]] ^ rc, fwd[t[15:8]], fwd[t[7:0]], fwd[t[31:24]]};
               rc = gmul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
         end
         for (int r = 0; r < 11; r++) begin
            rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
         end
      endfunction

      function bit [127:0] cipher(bit [127:0] x);
         bit [127:0] s;
         bit [7:0]   t [16];
         bit [7:0]   a0, a1, a2, a3;
         s = x ^ rk[0];
         for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  t[r + 4*c] = fwd[at(s, r + 4*((c + r) % 4))];
               end
            end
            if (rnd < 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                  t[4*c]   = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
                  t[4*c+1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
                  t[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
                  t[4*c+3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
               end
            end
            for (int i = 0; i < 16; i++) begin
               s[127 - 8*i -: 8] = t[i];
            end
            s ^= rk[rnd];
         end
         return s;
      endfunction

      function bit [127:0] decipher(bit [127:0] x);
         bit [127:0] s;
         bit [7:0]   t [16];
         bit [7:0]   a0, a1, a2, a3;
         s = x ^ rk[10];
         for (int rnd = 9; rnd >= 0; rnd--) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  t[r + 4*c] = rev[at(s, r + 4*((c - r + 4) % 4))];
               end
            end
            for (int i = 0; i < 16; i++) begin
               s[127 - 8*i -: 8] = t[i];
            end
            s ^= rk[rnd];
            if (rnd > 0) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = at(s, 4*c); a1 = at(s, 4*c+1); a2 = at(s, 4*c+2); a3 = at(s, 4*c+3);
                  t[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                             ^ gmul(a3, 8'd9);
                  t[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                             ^ gmul(a3, 8'd13);
                  t[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                             ^ gmul(a3, 8'd11);
                  t[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                             ^ gmul(a3, 8'd14);
               end
               for (int i = 0; i < 16; i++) begin
                  s[127 - 8*i -: 8] = t[i];
               end
            end
         end
         return s;
      endfunction

      function void push(bit [127:0] d, int n, bit l, bit e);
         aescbc_pkg::rsp_word_type r;
         r.out_high = d[127:64];
         r.out_low = d[63:0];
         r.out_bytes = 5'(n);
         r.out_last = l;
         r.pad_error = e;
         pending = {pending, r};
      endfunction

      // chain-encrypt one block and keep it as the new chain
      function bit [127:0] seal(bit [127:0] d);
         chain = cipher(d ^ chain);
         return chain;
      endfunction

      function void note_word(aescbc_pkg::req_word_type w);
         bit [127:0] d, pt;
         int         cnt, p;
         d = {w.data_high, w.data_low};
         if (w.is_iv) begin
            chain = d;
            return;
         end
         expand();
         if (w.mode == 1'b0) begin
            cnt = (w.byte_count > 16) ? 16 : w.byte_count;
            if (!w.last_block) begin
               push(seal(d), 16, 0, 0);
            end else if (cnt < 16) begin
               for (int i = cnt; i < 16; i++) begin
                  d[127 - 8*i -: 8] = 8'(16 - cnt);
               end
               push(seal(d), 16, 1, 0);
            end else begin
               push(seal(d), 16, 0, 0);
               push(seal({16{8'h10}}), 16, 1, 0);
            end
         end else begin
            pt = decipher(d) ^ chain;
            chain = d;
            if (!w.last_block) begin
               push(pt, 16, 0, 0);
            end else begin
               p = pt[7:0];
               if (p < 1 || p > 16) begin
                  push(pt, 16, 1, 1);
               end else begin
                  for (int i = 16 - p; i < 16; i++) begin
                     pt[127 - 8*i -: 8] = 8'h00;
                  end
                  push(pt, 16 - p, 1, 0);
               end
            end
         end
      endfunction

      function void check_word(aescbc_pkg::rsp_word_type got);
         aescbc_pkg::rsp_word_type want;
         if (pending.size() == 0) begin
            fails++;
            if (fails <= 10) begin
               $display("unexpected result word %h", got);
            end
            return;
         end
         want = pending.pop_front();
         if (got.out_high !== want.out_high || got.out_low !== want.out_low
             || got.out_bytes !== want.out_bytes || got.out_last !== want.out_last
             || got.pad_error !== want.pad_error) begin
            fails++;
            if (fails <= 10) begin
               $display("mismatch: expected data %h_%h bytes %0d last %b err %b",
                        want.out_high, want.out_low, want.out_bytes, want.out_last,
                        want.pad_error);
               $display("          actual   data %h_%h bytes %0d last %b err %b",
                        got.out_high, got.out_low, got.out_bytes, got.out_last,
                        got.pad_error);
            end
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   aescbc_pkg::req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   aescbc_pkg::rsp_word_type  rsp_word;
   logic          csr_we = 1'b0;
   logic [0:0]    csr_index = aescbc_pkg::CSR_KEY_HIGH;
   logic [63:0]   csr_wdata = '0;

   codec_scoreboard  sb = new();
   int               burst_left = 0;
   int               words_sent = 0;
   int               stall_mode = 0;
   int               stall_tick = 0;

   aes128_cbc_pkcs7_codec DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure: a randomly chosen pattern, from
   // always ready through random and sparse to a slow periodic stall.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 0) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (stall_tick % 16) >= 10;
      endcase
   end

   // every accepted result word goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word(rsp_word);
      end
   end

   function automatic bit [127:0] rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic aescbc_pkg::req_word_type make_word(bit m, bit iv, bit [127:0] d,
                                                          int cnt, bit l);
      aescbc_pkg::req_word_type w;
      w.mode = m;
      w.is_iv = iv;
      w.data_high = d[127:64];
      w.data_low = d[63:0];
      w.byte_count = 5'(cnt);
      w.last_block = l;
      return w;
   endfunction

   // Sender: bursts of random length with random gaps; valid stays up within a burst.
   task automatic send_word(aescbc_pkg::req_word_type w);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_word(w);
      burst_left--;
      words_sent++;
   endtask

   // IV word with random don't-care fields
   task automatic send_iv(bit [127:0] iv);
      send_word(make_word(1'($urandom_range(0, 1)), 1'b1, iv, $urandom_range(0, 31),
                          1'($urandom_range(0, 1))));
   endtask

   // One CBC message. Decrypt messages carry real ciphertext built from padded
   // plaintext, so the strip path is reached; bad_pad forces an invalid pad byte (0 or 17..255).
   task automatic send_message(bit m, int nblk, bit bad_pad);
      bit [127:0] prev, pt, ct;
      int         cnt, p;
      prev = rand_block();
      send_iv(prev);
      for (int b = 0; b < nblk; b++) begin
         pt = rand_block();
         if (m == 1'b0) begin
            cnt = (b == nblk - 1 && $urandom_range(0, 4) != 0) ? $urandom_range(0, 16)
                                                              : $urandom_range(0, 31);
            send_word(make_word(1'b0, 1'b0, pt, cnt, b == nblk - 1));
         end else begin
            if (b == nblk - 1) begin
               p = $urandom_range(1, 16);
               for (int i = 16 - p; i < 16; i++) begin
                  pt[127 - 8*i -: 8] = 8'(p);
               end
               if (bad_pad) begin
                  pt[7:0] = ($urandom_range(0, 1) == 0) ? 8'(17 + $urandom_range(0, 238)) : 8'h00;
               end
            end
            sb.expand();
            ct = sb.cipher(pt ^ prev);
            prev = ct;
            send_word(make_word(1'b1, 1'b0, ct, $urandom_range(0, 31), b == nblk - 1));
         end
      end
   endtask

   // Wait for every expected word, then let the codec idle before the next phase.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_key(bit [127:0] k);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= aescbc_pkg::CSR_KEY_HIGH;
      csr_wdata <= k[127:64];
      @(posedge clock);
      csr_index <= aescbc_pkg::CSR_KEY_LOW;
      csr_wdata <= k[63:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.key = k;
   endtask

   initial begin
      bit [127:0] ones;
      ones = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset key and zero chain first, then field extremes.
      send_word(make_word(1'b0, 1'b0, '0, 16, 1'b0));         // no IV, chain from reset
      send_iv('0);
      send_word(make_word(1'b0, 1'b0, ones, 31, 1'b0));        // count ignored when not last
      send_word(make_word(1'b0, 1'b0, ones, 0, 1'b1));         // whole pad block
      send_iv(ones);
      send_word(make_word(1'b0, 1'b0, '0, 15, 1'b1));          // single pad byte
      send_word(make_word(1'b0, 1'b0, ones, 16, 1'b1));        // full last, extra block
      send_word(make_word(1'b0, 1'b0, '0, 31, 1'b1));          // count saturates
      send_word(make_word(1'b1, 1'b0, '0, 0, 1'b0));           // raw decrypt
      send_word(make_word(1'b1, 1'b0, ones, 31, 1'b1));        // arbitrary pad byte
      send_message(1'b1, 1, 1'b0);
      send_message(1'b1, 2, 1'b1);
      drain();

      // Key phases: all zeros, all ones, then random keys.
      for (int ph = 0; ph < 6; ph++) begin
         write_key(ph == 0 ? 128'd0 : ph == 1 ? ones : rand_block());
         while (words_sent < 320 * (ph + 1)) begin
            case ($urandom_range(0, 9))
               0: send_word(make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      rand_block(), $urandom_range(0, 31),
                                      1'($urandom_range(0, 1))));
               1: send_message(1'($urandom_range(0, 1)), $urandom_range(1, 2), 1'b1);
               2, 3, 4, 5: send_message(1'b0, $urandom_range(1, 5), 1'b0);
               default: send_message(1'b1, $urandom_range(1, 5), 1'b0);
            endcase
         end
         drain();
      end

      if (sb.fails == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("testbench failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aescbc_pkg.sv
hw/rtl/aescbc_front.sv
hw/rtl/aescbc_fifo.sv
hw/rtl/aescbc_engine.sv
hw/rtl/aes128_cbc_pkcs7_codec.sv
tb/testbench.sv
